/* rtl/core/bbds_pkg.sv */
// Shared types, constants and the control program of the BCD display scan unit.
package bbds_pkg;

  localparam int VALUE_W      = 32;
  localparam int DABBLE_STEPS = 32;
  localparam int CNT_W        = 5;
  localparam int COUNT_W      = 4;
  localparam int BCD_W        = 4;
  localparam int TDATA_OUT_W  = 8;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CNT_W-1:0] CNT_LAST_VAL = CNT_W'(DABBLE_STEPS - 1);

  typedef enum logic [1:0] {
    STEP_WAIT   = 2'd0,
    STEP_DABBLE = 2'd1,
    STEP_CHECK  = 2'd2,
    STEP_EMIT   = 2'd3
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_IN_ACCEPT = 3'd1,
    COND_CNT_LAST  = 3'd2,
    COND_N_ZERO    = 3'd3,
    COND_EMIT_LAST = 3'd4
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  dabble;
    logic  idx_clear;
    logic  emit;
    cond_t cond;
    step_t target_t;
    step_t target_f;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic cnt_last;
    logic n_zero;
    logic emit_last;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '0;
    unique case (step)
      STEP_WAIT: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN_ACCEPT;
        w.target_t = STEP_DABBLE;
        w.target_f = STEP_WAIT;
      end
      STEP_DABBLE: begin
        w.dabble   = 1'b1;
        w.cond     = COND_CNT_LAST;
        w.target_t = STEP_CHECK;
        w.target_f = STEP_DABBLE;
      end
      STEP_CHECK: begin
        w.idx_clear = 1'b1;
        w.cond      = COND_N_ZERO;
        w.target_t  = STEP_WAIT;
        w.target_f  = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit     = 1'b1;
        w.cond     = COND_EMIT_LAST;
        w.target_t = STEP_WAIT;
        w.target_f = STEP_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/bbds_sequencer.sv */
// Step counter and jump logic that walks the control program.
module bbds_sequencer
  import bbds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t pc;
  step_t pc_next;
  logic  cond_true;

  always_comb begin
    ctrl = ucode(pc);
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_IN_ACCEPT: cond_true = status.in_accept;
      COND_CNT_LAST:  cond_true = status.cnt_last;
      COND_N_ZERO:    cond_true = status.n_zero;
      COND_EMIT_LAST: cond_true = status.emit_last;
      default:        cond_true = 1'b0;
    endcase
    pc_next = cond_true ? ctrl.target_t : ctrl.target_f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/core/bbds_datapath.sv */
// Double-dabble shift registers, digit index and output register.
module bbds_datapath
  import bbds_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  input  logic [COUNT_W-1:0]     count,
  output status_t                status,
  input  logic                   s_tvalid,
  input  logic [VALUE_W-1:0]     s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tlast
);

  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd [MAX_DIGITS];
  logic [BCD_W-1:0]   adj [MAX_DIGITS];
  logic [CNT_W-1:0]   cnt;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] sel;
  logic               in_accept;
  logic               emit_fire;
  logic               is_last;

  assign in_accept = s_tvalid & ctrl.in_ready;
  assign emit_fire = ctrl.emit & (~m_tvalid | m_tready);
  assign sel       = count - COUNT_W'(1) - idx;
  assign is_last   = (idx == count - COUNT_W'(1));

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      adj[k] = (bcd[k] >= BCD_W'(5)) ? bcd[k] + BCD_W'(3) : bcd[k];
    end
  end

  assign status.in_accept = in_accept;
  assign status.cnt_last  = (cnt == CNT_LAST_VAL);
  assign status.n_zero    = (count == '0);
  assign status.emit_last = emit_fire & is_last;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bin <= s_tdata;
      cnt <= '0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
        bcd[k] <= '0;
      end
    end else if (ctrl.dabble) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
      bcd[0] <= {adj[0][BCD_W-2:0], bin[VALUE_W-1]};
      for (int k = 1; k < MAX_DIGITS; k++) begin
        bcd[k] <= {adj[k][BCD_W-2:0], adj[k-1][BCD_W-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.idx_clear) begin
      idx <= '0;
    end else if (emit_fire) begin
      idx <= idx + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {idx, bcd[sel[DIG_IDX_W-1:0]]};
      m_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

/* rtl/core/binary_to_bcd_display_scan_unit.sv */
// Top level of the binary to BCD display scan unit: register port and core.
// Converts each 32-bit unsigned value by 32 double-dabble shift steps, then
// emits one digit per cycle while the output is not held, most significant
// first, as many as digit_count sets (saturated at MAX_DIGITS; a count of
// zero emits nothing). An item runs through 32 shift steps and one check
// step, then n emit steps, n being the digit count, as the control program
// steps through them. Holding the output delays the item, and the next value
// can be taken in the cycle after the last digit is registered. The last digit
// waits in the output register while the next value is taken. Digits beyond
// the count are dropped, so the value shown is modulo 10 to the count.
module binary_to_bcd_display_scan_unit
  import bbds_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [3:0] bcd_digit, [7:4] digit_select
  output logic                   m_tlast
);

  logic [COUNT_W-1:0] digit_count;
  logic [COUNT_W-1:0] count;
  ctrl_t              ctrl;
  status_t            status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? PDATA_W'(digit_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_W'(3);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      digit_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign count = (digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : digit_count;

  assign s_tready = ctrl.in_ready;

  bbds_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  bbds_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .count    (count),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* bench/tb_binary_to_bcd_display_scan_unit.sv */
// Self-checking bench for the BCD display scan unit: digit prediction, register setup, stalls.
module tb_binary_to_bcd_display_scan_unit import bbds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISPLAY_DIGITS = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 64;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASE_ITEMS    = 30;
  localparam logic [PADDR_W-1:0] DIGIT_COUNT_ADDR = 3'd0;
  localparam logic [PADDR_W-1:0] SPARE_ADDR       = 3'd4;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [COUNT_W-1:0] position;
    logic               last;
  } digit_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [VALUE_W-1:0]     s_tdata = '0;   // [31:0] value
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;        // [3:0] bcd_digit, [7:4] digit_select
  logic                   m_tlast;

  digit_t             expected_digits[$];
  logic [COUNT_W-1:0] display_count = COUNT_W'(3);
  int                 failures = 0;
  int                 tx_idle_pct = 11;
  int                 rx_idle_pct = 50;
  logic               hold_start = 1'b0;
  int                 hold_left = 0;
  int                 cycle_count = 0;

  binary_to_bcd_display_scan_unit #(.MAX_DIGITS(DISPLAY_DIGITS)) i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    digit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected transaction: bcd_digit %0d digit_select %0d last %0b",
               m_tdata[3:0], m_tdata[7:4], m_tlast);
        failures++;
      end else begin
        want = expected_digits.pop_front();
        if (m_tdata[3:0] !== want.bcd) begin
          $error("bcd_digit: expected %0d, actual %0d", want.bcd, m_tdata[3:0]);
          failures++;
        end
        if (m_tdata[7:4] !== want.position) begin
          $error("digit_select: expected %0d, actual %0d", want.position, m_tdata[7:4]);
          failures++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_tlast);
          failures++;
        end
      end
    end
    m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic predict_display(input logic [VALUE_W-1:0] value);
    logic [BCD_W-1:0] digits[DISPLAY_DIGITS];
    logic [VALUE_W-1:0] rest;
    int n;
    n = (display_count > DISPLAY_DIGITS) ? DISPLAY_DIGITS : int'(display_count);
    rest = value;
    for (int i = n - 1; i >= 0; i--) begin
      digits[i] = BCD_W'(rest % 10);
      rest = rest / 10;
    end
    for (int i = 0; i < n; i++) begin
      expected_digits.push_back('{bcd: digits[i], position: COUNT_W'(i), last: (i == n - 1)});
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    predict_display(value);
  endtask

  task automatic wait_for_display();
    s_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == DIGIT_COUNT_ADDR) display_count = data[COUNT_W-1:0];
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input int n);
    longint unsigned span;
    longint unsigned wide;
    span = 1;
    for (int i = 0; i < n && i < DISPLAY_DIGITS; i++) span = span * 10;
    wide = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return $urandom;
      1: return VALUE_W'(wide % span);
      2: return VALUE_W'(span - 1);
      3: return VALUE_W'(span + $urandom_range(2) - 1);
      4: return $urandom_range(1) ? '1 : '0;
      default: return $urandom_range(99);
    endcase
  endfunction

  task automatic test_reset_count();
    send_value(0);
    send_value(999);
    send_value(1000);
    send_value(123);
    wait_for_display();
  endtask

  task automatic test_count_extremes();
    write_register(DIGIT_COUNT_ADDR, 1);
    send_value(0);
    send_value(9);
    send_value(10);
    send_value('1);
    wait_for_display();
    write_register(DIGIT_COUNT_ADDR, 10);
    send_value(0);
    send_value('1);
    send_value(1_000_000_000);
    send_value(999_999_999);
    wait_for_display();
    write_register(DIGIT_COUNT_ADDR, 0);
    send_value(5);
    send_value('1);
    wait_for_display();
    write_register(DIGIT_COUNT_ADDR, 15);
    send_value(1_234_567_890);
    wait_for_display();
    write_register(DIGIT_COUNT_ADDR, 11);
    send_value('1);
    wait_for_display();
    write_register(SPARE_ADDR, 5);
    send_value(32'd4_000_000_001);
    wait_for_display();
  endtask

  task automatic test_backpressure();
    write_register(DIGIT_COUNT_ADDR, 10);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 8; i++) send_value($urandom);
    wait_for_display();
  endtask

  task automatic test_random_values();
    int counts[12];
    counts = '{10, 1, 7, 2, 15, 4, 9, 8, 5, 12, 6, 3};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        tx_idle_pct = 50;
        rx_idle_pct = 11;
      end else if (phase == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_register(DIGIT_COUNT_ADDR, counts[phase]);
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(pick_value(int'(display_count)));
      wait_for_display();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_count();
    test_count_extremes();
    test_backpressure();
    test_random_values();
    if (failures == 0 && expected_digits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
